[hw/rtl/ele_pkg.sv]
// Shared types, constants and helper functions for the echoing line editor.
// No dependencies; imported by echoing_line_editor_unit and its testbench.
package ele_pkg;

	localparam int LINE_DEPTH = 32;
	localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int POS_W      = $clog2(LINE_DEPTH + 1);

	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_NUL = 8'h00;

	localparam logic CMD_RX   = 1'b0;
	localparam logic CMD_TAKE = 1'b1;

	typedef enum logic [1:0] {
		KIND_ECHO = 2'd0,
		KIND_LINE = 2'd1,
		KIND_NONE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ECHO,
		ST_READ
	} state_t;

	typedef enum logic [1:0] {
		BYTE_TEXT,
		BYTE_ERASE,
		BYTE_ENTER,
		BYTE_OTHER
	} byte_class_t;

	// multi-beat echo sequences
	typedef enum logic {
		SEQ_ERASE,   // BS, space, BS
		SEQ_ENTER    // CR, LF
	} echo_seq_t;

	function automatic byte_class_t classify(input logic [7:0] b);
		byte_class_t c;
		case (b) inside
			[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], CH_SP: c = BYTE_TEXT;
			CH_BS, CH_DEL:                                      c = BYTE_ERASE;
			CH_CR, CH_LF:                                       c = BYTE_ENTER;
			default:                                            c = BYTE_OTHER;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] echo_byte(input echo_seq_t s, input logic [1:0] idx);
		logic [7:0] b;
		case (s)
			SEQ_ERASE: b = (idx == 2'd1) ? CH_SP : CH_BS;
			SEQ_ENTER: b = (idx == 2'd0) ? CH_CR : CH_LF;
			default:   b = CH_NUL;
		endcase
		return b;
	endfunction

	// index of the final beat of a sequence
	function automatic logic [1:0] echo_last(input echo_seq_t s);
		logic [1:0] n;
		case (s)
			SEQ_ERASE: n = 2'd2;
			SEQ_ENTER: n = 2'd1;
			default:   n = 2'd0;
		endcase
		return n;
	endfunction

endpackage

[hw/rtl/ele_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ele_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

[hw/rtl/echoing_line_editor_unit.sv]
// Echoing line editor top level: command FSM, position registers and line store.
// Depends on ele_pkg and ele_ram.

// Collects received ASCII bytes into a LINE_DEPTH-entry line store and echoes
// them. A beat is accepted on a rising edge with start high and busy low; every
// result beat is shown for exactly one cycle with strobe high and cannot be held
// off. A stored character, an ignored or refused byte, and a take with no line
// ready leave the unit idle, so the next beat can be accepted straight away;
// backspace gives three echo beats (BS, space, BS); CR/LF gives two (CR, LF); a
// take with a line ready gives one beat per stored byte plus the zero terminator,
// with the line store walked one entry per cycle. Each result is registered in
// the output beat register and appears the cycle after accept, except a line
// readout, whose first beat passes through the read state and then the output
// beat register. The store is written only from idle and its read data is used
// only during a readout, and busy keeps the two apart, so no forwarding is
// needed. The store has no reset; only entries below the recorded length are
// ever output, and those were always written first.
module echoing_line_editor_unit
	import ele_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       cmd,
	input  logic [7:0] rx_byte,
	output logic       strobe,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic       last
);

	state_t            state_q, state_d;
	logic [POS_W-1:0]  wp_q, wp_d;          // next free entry
	logic [POS_W-1:0]  len_q, len_d;        // finished line length
	logic              ready_q, ready_d;    // finished line pending
	logic [POS_W-1:0]  rd_idx_q, rd_idx_d;  // readout position
	echo_seq_t         seq_q, seq_d;
	logic [1:0]        eidx_q, eidx_d;

	// output beat register
	logic              strobe_q, strobe_d;
	kind_t             kind_q, kind_d;
	logic [7:0]        data_q, data_d;
	logic              last_q, last_d;

	// line store port
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data;

	logic              accept;
	byte_class_t       cls;
	logic              echo_done;
	logic [POS_W-1:0]  rd_idx_inc;

	ele_ram #(
		.WIDTH(8),
		.DEPTH(LINE_DEPTH)
	) u_line_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(rx_byte),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign cls        = classify(rx_byte);
	assign echo_done  = (eidx_q == echo_last(seq_q));
	assign rd_idx_inc = rd_idx_q + POS_W'(1);
	assign wr_addr    = wp_q[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			wp_q     <= '0;
			len_q    <= '0;
			ready_q  <= 1'b0;
			rd_idx_q <= '0;
			seq_q    <= SEQ_ERASE;
			eidx_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			wp_q     <= wp_d;
			len_q    <= len_d;
			ready_q  <= ready_d;
			rd_idx_q <= rd_idx_d;
			seq_q    <= seq_d;
			eidx_q   <= eidx_d;
			strobe_q <= strobe_d;
		end
	end

	// payload of the output beat, qualified by strobe_q
	always_ff @(posedge clk) begin
		kind_q <= kind_d;
		data_q <= data_d;
		last_q <= last_d;
	end

	always_comb begin
		state_d  = state_q;
		wp_d     = wp_q;
		len_d    = len_q;
		ready_d  = ready_q;
		rd_idx_d = rd_idx_q;
		seq_d    = seq_q;
		eidx_d   = eidx_q;
		strobe_d = 1'b0;
		kind_d   = KIND_ECHO;
		data_d   = CH_NUL;
		last_d   = 1'b0;
		wr_en    = 1'b0;
		rd_addr  = '0;   // idle: entry 0 is prefetched for a readout

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd == CMD_TAKE) begin
						if (ready_q) begin
							rd_idx_d = '0;
							state_d  = ST_READ;
						end else begin
							strobe_d = 1'b1;
							kind_d   = KIND_NONE;
							last_d   = 1'b1;
						end
					end else begin
						case (cls)
							BYTE_TEXT: begin
								if (!ready_q && (wp_q < POS_W'(LINE_DEPTH))) begin
									wr_en    = 1'b1;
									wp_d     = wp_q + POS_W'(1);
									strobe_d = 1'b1;
									data_d   = rx_byte;
									last_d   = 1'b1;
								end
							end
							BYTE_ERASE: begin
								if (wp_q != '0) begin
									wp_d     = wp_q - POS_W'(1);
									strobe_d = 1'b1;
									data_d   = echo_byte(SEQ_ERASE, 2'd0);
									seq_d    = SEQ_ERASE;
									eidx_d   = 2'd1;
									state_d  = ST_ECHO;
								end
							end
							BYTE_ENTER: begin
								// replaces any pending line
								len_d    = wp_q;
								wp_d     = '0;
								ready_d  = 1'b1;
								strobe_d = 1'b1;
								data_d   = echo_byte(SEQ_ENTER, 2'd0);
								seq_d    = SEQ_ENTER;
								eidx_d   = 2'd1;
								state_d  = ST_ECHO;
							end
							default: begin
							end
						endcase
					end
				end
			end

			ST_ECHO: begin
				strobe_d = 1'b1;
				data_d   = echo_byte(seq_q, eidx_q);
				last_d   = echo_done;
				eidx_d   = eidx_q + 2'd1;
				if (echo_done) begin
					state_d = ST_IDLE;
				end
			end

			ST_READ: begin
				// rd_data holds entry rd_idx_q, issued the cycle before
				strobe_d = 1'b1;
				kind_d   = KIND_LINE;
				rd_addr  = rd_idx_inc[ADDR_W-1:0];
				if (rd_idx_q == len_q) begin
					data_d  = CH_NUL;
					last_d  = 1'b1;
					ready_d = 1'b0;
					state_d = ST_IDLE;
				end else begin
					data_d   = rd_data;
					rd_idx_d = rd_idx_inc;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign strobe    = strobe_q;
	assign kind      = kind_q;
	assign data_byte = data_q;
	assign last      = last_q;

	// A pending line always leaves the write position rewound.
	a_ready_rewound: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> (wp_q == '0))
		else $error("line pending with nonzero write position");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(wp_q <= POS_W'(LINE_DEPTH)) && (len_q <= POS_W'(LINE_DEPTH)))
		else $error("position or length beyond line depth");

	a_no_line: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd == CMD_TAKE) && !ready_q)
			|=> (strobe && (kind == KIND_NONE) && last && (data_byte == CH_NUL) && !busy))
		else $error("take without line did not give a single no-line beat");

	a_char_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd == CMD_RX) && (cls == BYTE_TEXT) && !ready_q
			&& (wp_q < POS_W'(LINE_DEPTH)))
			|=> (strobe && (kind == KIND_ECHO) && last && (data_byte == $past(rx_byte))))
		else $error("stored character not echoed");

	a_line_term: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (kind == KIND_LINE) && last) |-> ((data_byte == CH_NUL) && !ready_q))
		else $error("line readout ended without terminator or with line still pending");

endmodule

[tb/sv/tb_echoing_line_editor_unit.sv]
// Self-checking testbench for echoing_line_editor_unit: directed edits, then random lines.
// Depends on ele_pkg and the unit RTL. A behavioral line editor predicts every result beat.
module tb_echoing_line_editor_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import ele_pkg::*;

	// one result beat as the block should emit it
	typedef struct {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} ed_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic       cmd = CMD_RX;
	logic [7:0] rx_byte = CH_NUL;
	logic       strobe;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic       last;

	// shadow copy of the editor state
	logic [7:0]  line_mem [LINE_DEPTH];
	int unsigned wr_pos = 0;
	int unsigned line_len = 0;
	bit          line_pending = 1'b0;

	ed_beat_t awaited_beats[$];   // result beats still owed by the block, oldest first
	int       fail_count = 0;
	int       items_sent = 0;     // accepted items, all tests together
	bit       burst_mode = 1'b0;  // no sender gaps while set

	echoing_line_editor_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.rx_byte   (rx_byte),
		.strobe    (strobe),
		.kind      (kind),
		.data_byte (data_byte),
		.last      (last)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run (a few hundred items, each with
	// at most a full line readout of work plus a long sender gap).
	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic void owe_beat(input kind_t k, input logic [7:0] d, input logic l);
		ed_beat_t b;
		b.kind = k;
		b.data = d;
		b.last = l;
		awaited_beats.push_back(b);
	endfunction

	// Applies one accepted item to the shadow state and queues the beats it
	// must produce. Returns the number of beats.
	function automatic int edit_line_model(input logic c, input logic [7:0] b);
		int n;
		n = 0;
		if (c == CMD_TAKE) begin
			if (line_pending) begin
				// stored characters, then the zero terminator flagged last
				for (int i = 0; i < int'(line_len); i++)
					owe_beat(KIND_LINE, line_mem[i], 1'b0);
				owe_beat(KIND_LINE, CH_NUL, 1'b1);
				line_pending = 1'b0;
				n = line_len + 1;
			end else begin
				owe_beat(KIND_NONE, CH_NUL, 1'b1);
				n = 1;
			end
		end else if (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], CH_SP}) begin
			// text is refused silently while a line waits or the store is full
			if (!line_pending && wr_pos < LINE_DEPTH) begin
				line_mem[wr_pos] = b;
				wr_pos++;
				owe_beat(KIND_ECHO, b, 1'b1);
				n = 1;
			end
		end else if (b == CH_BS || b == CH_DEL) begin
			if (wr_pos > 0) begin
				wr_pos--;
				owe_beat(KIND_ECHO, CH_BS, 1'b0);
				owe_beat(KIND_ECHO, CH_SP, 1'b0);
				owe_beat(KIND_ECHO, CH_BS, 1'b1);
				n = 3;
			end
		end else if (b == CH_CR || b == CH_LF) begin
			// also while a line is pending: that line becomes the empty line
			line_len = wr_pos;
			wr_pos = 0;
			line_pending = 1'b1;
			owe_beat(KIND_ECHO, CH_CR, 1'b0);
			owe_beat(KIND_ECHO, CH_LF, 1'b1);
			n = 2;
		end
		return n;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 80) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	function automatic logic [7:0] text_char();
		case ($urandom_range(0, 3))
			0:       return 8'($urandom_range(8'h30, 8'h39));
			1:       return 8'($urandom_range(8'h41, 8'h5A));
			2:       return 8'($urandom_range(8'h61, 8'h7A));
			default: return CH_SP;
		endcase
	endfunction

	// Present one beat, hold it until the block takes it, predict, then idle.
	// With no gap start stays high so the next call can chain straight on.
	task automatic send_beat(input logic c, input logic [7:0] b);
		int gap;
		start <= 1'b1;
		cmd <= c;
		rx_byte <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		void'(edit_line_model(c, b));
		items_sent++;
		gap = burst_mode ? 0 : idle_gap();
		if (gap > 0) begin
			// junk on the payload while start is low must be ignored
			start <= 1'b0;
			cmd <= 1'($urandom);
			rx_byte <= 8'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_beat(CMD_RX, b);
	endtask

	task automatic take_line();
		send_beat(CMD_TAKE, 8'($urandom));
	endtask

	// sender holds off until every owed beat has arrived
	task automatic wait_until_drained();
		start <= 1'b0;
		do
			@(posedge clk);
		while (awaited_beats.size() != 0);
	endtask

	// Result checker: every strobe beat is matched against the oldest owed beat.
	always @(posedge clk) begin
		ed_beat_t want;
		if (arst_n && strobe) begin
			if (awaited_beats.size() == 0) begin
				$display("%0t: unexpected beat kind=%0d data=%02h last=%0b",
				         $time, kind, data_byte, last);
				fail_count++;
			end else begin
				want = awaited_beats.pop_front();
				if (kind !== want.kind) begin
					$display("%0t: kind expected %0d got %0d", $time, want.kind, kind);
					fail_count++;
				end
				if (data_byte !== want.data) begin
					$display("%0t: data_byte expected %02h got %02h",
					         $time, want.data, data_byte);
					fail_count++;
				end
				if (last !== want.last) begin
					$display("%0t: last expected %0b got %0b", $time, want.last, last);
					fail_count++;
				end
			end
		end
	end

	// Take with nothing pending, erase at position zero.
	task automatic test_idle_commands();
		take_line();
		send_byte(CH_BS);
	endtask

	// Character class edges, both ends of the byte range, high-bit bytes.
	task automatic test_char_classes();
		logic [7:0] probe [16] = '{8'h2F, 8'h30, 8'h39, 8'h3A, 8'h40, 8'h41, 8'h5A, 8'h5B,
		                           8'h60, 8'h61, 8'h7A, 8'h7B, CH_SP, 8'h00, 8'h80, 8'hFF};
		foreach (probe[i])
			send_byte(probe[i]);
		send_byte(CH_CR);
		take_line();
	endtask

	// Both erase codes, erase past the start, line end by LF.
	task automatic test_erase();
		send_byte("a");
		send_byte("b");
		send_byte(CH_BS);
		send_byte(CH_DEL);
		send_byte(CH_DEL);
		send_byte(CH_LF);
		take_line();
	endtask

	// Text refused while a line waits; a second enter empties the waiting line.
	task automatic test_pending_line();
		send_byte("Q");
		send_byte(CH_CR);
		send_byte("x");
		send_byte(CH_LF);
		take_line();
		take_line();
	endtask

	// Overfill the store, erase from full, refill the last entry, read all 32.
	task automatic test_full_store();
		for (int i = 0; i < LINE_DEPTH + 2; i++)
			send_byte(text_char());
		send_byte(CH_DEL);
		send_byte(text_char());
		send_byte(text_char());
		send_byte(CH_CR);
		take_line();
	endtask

	// Mostly well-formed lines with random content and edits, some noise.
	task automatic test_random_lines();
		int target;
		int len;
		int r;
		target = 230;
		while (items_sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 3)
				burst_mode = ~burst_mode;
			else if (r < 5)
				wait_until_drained();
			if (r < 12) begin
				send_beat(1'($urandom), 8'($urandom));
			end else begin
				r = $urandom_range(0, 99);
				len = (r < 70) ? $urandom_range(0, 8) :
				      (r < 90) ? $urandom_range(9, 31) : $urandom_range(32, 36);
				repeat (len) begin
					r = $urandom_range(0, 99);
					if (r < 8)
						send_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
					else if (r < 12)
						send_byte(8'($urandom));
					else
						send_byte(text_char());
				end
				send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
				r = $urandom_range(0, 99);
				if (r < 10) begin
					send_byte(text_char());
					send_byte(CH_BS);
				end else if (r < 20) begin
					send_byte(CH_LF);
				end
				take_line();
				if (r >= 90)
					take_line();
			end
		end
		burst_mode = 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_commands();
		test_char_classes();
		test_erase();
		test_pending_line();
		wait_until_drained();
		test_full_store();
		test_random_lines();

		// all owed beats in, then a quiet spell to catch stray strobes
		wait_until_drained();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/ele_pkg.sv
hw/rtl/ele_ram.sv
hw/rtl/echoing_line_editor_unit.sv
tb/sv/tb_echoing_line_editor_unit.sv
